// File: rtl/matrix_inverse_3x3_top_assert.svh
// Assertion macros shared by the 3x3 matrix inverse RTL.
`ifndef MATRIX_INVERSE_3X3_TOP_ASSERT_SVH
`define MATRIX_INVERSE_3X3_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MI3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mi3_pkg.sv
// Types and constants of the 3x3 matrix inverse.
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned DET_W  = 97;
  localparam int unsigned QUO_W  = 33;
  localparam int unsigned THR_W  = 63;
  localparam int unsigned NUM_E  = 9;
  localparam int unsigned NUM_P  = 18;

  // Configuration port.
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [ADDR_W-1:0] ADDR_THRESH  = 4'h0;
  localparam logic [THR_W-1:0]  THRESH_RESET = 63'd281;

  // Operand indexes of the eighteen cofactor products: cofactor k is
  // product 2k minus product 2k+1.
  localparam int unsigned PA [NUM_P] =
    '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int unsigned PB [NUM_P] =
    '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

  // Control that travels alongside the divider lanes.
  typedef struct packed {
    logic             valid;
    logic             singular;
    logic [NUM_E-1:0] neg;
  } ctl_t;

endpackage

// File: rtl/mi3_div.sv
// Pipelined restoring divider lane, one quotient bit per stage.
`timescale 1ns / 1ps
module mi3_div #(
  parameter int unsigned NUM_W = 96
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [NUM_W-1:0]           num,
  input  logic [mi3_pkg::DET_W-1:0]  den,
  output logic [mi3_pkg::QUO_W-1:0]  quo,
  output logic                       ovf
);

  localparam int unsigned QW = mi3_pkg::QUO_W;
  localparam int unsigned DW = mi3_pkg::DET_W;
  localparam int unsigned CW = DW + QW;

  logic [CW-1:0] rem_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] quo_r [QW+1];
  logic          ovf_r [QW+1];

  // First stage: flag quotients that need more than the kept bits.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= CW'(num);
      den_r[0] <= den;
      quo_r[0] <= '0;
      ovf_r[0] <= (CW'(num) >= {den, {QW{1'b0}}});
    end
  end

  // One compare and subtract per stage, most significant bit first.
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int unsigned B = QW - k;
    logic [CW-1:0] sh;
    logic          ge;
    assign sh = CW'(den_r[k-1]) << B;
    assign ge = (rem_r[k-1] >= sh);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? (rem_r[k-1] - sh) : rem_r[k-1];
        den_r[k] <= den_r[k-1];
        quo_r[k] <= quo_r[k-1] | (ge ? (QW'(1) << B) : '0);
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign quo = quo_r[QW];
  assign ovf = ovf_r[QW];

endmodule

// File: rtl/matrix_inverse_3x3_top.sv
// Top level of the pipelined 3x3 matrix inverse (adjugate method).
`timescale 1ns / 1ps
// Usage:
// Input channel: in_valid/in_stall with the nine signed entries in_00..in_22.
// A transfer takes place at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with the nine inverse entries and
// out_singular; a transfer takes place when out_valid is high and out_stall low.
// Throughput is one matrix per cycle while no result is held by out_stall. From
// the input transfer to out_valid a matrix passes seven stages for products,
// cofactors, determinant and magnitudes, 34 stages of the bit-per-stage dividers and one output stage.
// The threshold is set through the APB port at byte address 0 (64-bit data)
// and may only change while the pipeline is empty.
// Reset (rst_n low, synchronous) clears every valid bit and loads the
// threshold with 281; no clearing pass is needed.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is lost or repeated.
// A matrix whose determinant magnitude is zero or below the threshold gives
// all-zero entries with out_singular set.
`include "matrix_inverse_3x3_top_assert.svh"
module matrix_inverse_3x3_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mi3_pkg::DATA_W-1:0]    in_00,
  input  logic signed [mi3_pkg::DATA_W-1:0]    in_01,
  input  logic signed [mi3_pkg::DATA_W-1:0]    in_02,
  input  logic signed [mi3_pkg::DATA_W-1:0]    in_10,
  input  logic signed [mi3_pkg::DATA_W-1:0]    in_11,
  input  logic signed [mi3_pkg::DATA_W-1:0]    in_12,
  input  logic signed [mi3_pkg::DATA_W-1:0]    in_20,
  input  logic signed [mi3_pkg::DATA_W-1:0]    in_21,
  input  logic signed [mi3_pkg::DATA_W-1:0]    in_22,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mi3_pkg::DATA_W-1:0]    out_00,
  output logic signed [mi3_pkg::DATA_W-1:0]    out_01,
  output logic signed [mi3_pkg::DATA_W-1:0]    out_02,
  output logic signed [mi3_pkg::DATA_W-1:0]    out_10,
  output logic signed [mi3_pkg::DATA_W-1:0]    out_11,
  output logic signed [mi3_pkg::DATA_W-1:0]    out_12,
  output logic signed [mi3_pkg::DATA_W-1:0]    out_20,
  output logic signed [mi3_pkg::DATA_W-1:0]    out_21,
  output logic signed [mi3_pkg::DATA_W-1:0]    out_22,
  output logic                                 out_singular,
  // configuration port
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [mi3_pkg::ADDR_W-1:0]           cfg_paddr,
  input  logic [mi3_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [mi3_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int unsigned DW    = mi3_pkg::DATA_W;
  localparam int unsigned PW    = mi3_pkg::PROD_W;
  localparam int unsigned TW    = mi3_pkg::DET_W;
  localparam int unsigned QW    = mi3_pkg::QUO_W;
  localparam int unsigned NE    = mi3_pkg::NUM_E;
  localparam int unsigned NUM_W = PW + 2 * FRAC_BITS;
  localparam int unsigned DIV_LAT = QW + 1;
  localparam int unsigned HW    = PW - DW;

  localparam logic [QW-1:0] POS_LIM = QW'(33'h0_7FFF_FFFF);
  localparam logic [QW-1:0] NEG_LIM = QW'(33'h0_8000_0000);
  localparam logic signed [DW-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] SAT_MIN = 32'sh8000_0000;

  logic en;

  // Configuration register.
  logic [mi3_pkg::THR_W-1:0] thresh_r;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr == mi3_pkg::ADDR_THRESH);
  assign cfg_prdata = (cfg_paddr == mi3_pkg::ADDR_THRESH) ? {1'b0, thresh_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= mi3_pkg::THRESH_RESET;
    end else if (cfg_wr) begin
      thresh_r <= cfg_pwdata[mi3_pkg::THR_W-1:0];
    end
  end

  // The whole pipeline advances unless a finished result is held.
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = out_valid_r && out_stall;

  // Valid bits of the front stages.
  logic [6:1] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:1], in_valid};
    end
  end

  // Stage 1: input registers.
  logic signed [DW-1:0] m1_r [NE];
  always_ff @(posedge clk) begin
    if (en) begin
      m1_r[0] <= in_00; m1_r[1] <= in_01; m1_r[2] <= in_02;
      m1_r[3] <= in_10; m1_r[4] <= in_11; m1_r[5] <= in_12;
      m1_r[6] <= in_20; m1_r[7] <= in_21; m1_r[8] <= in_22;
    end
  end

  // Stage 2: eighteen 32x32 products; row 0 travels on.
  logic signed [PW-1:0] p2_r [mi3_pkg::NUM_P];
  logic signed [DW-1:0] row2_r [3];
  for (genvar p = 0; p < mi3_pkg::NUM_P; p++) begin : g_prod
    always_ff @(posedge clk) begin
      if (en) p2_r[p] <= m1_r[mi3_pkg::PA[p]] * m1_r[mi3_pkg::PB[p]];
    end
  end

  // Stage 3: cofactors.
  logic signed [PW-1:0] cof3_r [NE];
  logic signed [DW-1:0] row3_r [3];
  for (genvar k = 0; k < NE; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (en) cof3_r[k] <= p2_r[2*k] - p2_r[2*k+1];
    end
  end

  // Stage 4: row 0 times the first-column cofactors, in two halves each.
  logic signed [PW-1:0]   ph4_r [3];
  logic signed [PW:0]     pl4_r [3];
  logic signed [PW-1:0]   cof4_r [NE];
  // Stage 5: full products.
  logic signed [TW-1:0]   term5_r [3];
  logic signed [PW-1:0]   cof5_r [NE];
  // Stage 6: determinant.
  logic signed [TW-1:0]   det6_r;
  logic signed [PW-1:0]   cof6_r [NE];

  always_ff @(posedge clk) begin
    if (en) begin
      row2_r[0] <= m1_r[0];
      row2_r[1] <= m1_r[1];
      row2_r[2] <= m1_r[2];
      row3_r <= row2_r;
      cof4_r <= cof3_r;
      cof5_r <= cof4_r;
      cof6_r <= cof5_r;
      det6_r <= term5_r[0] + term5_r[1] + term5_r[2];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_det
    logic signed [HW-1:0] chi;
    logic signed [DW:0]   clo;
    assign chi = cof3_r[3*j][PW-1:DW];
    assign clo = $signed({1'b0, cof3_r[3*j][DW-1:0]});
    always_ff @(posedge clk) begin
      if (en) begin
        ph4_r[j]   <= row3_r[j] * chi;
        pl4_r[j]   <= row3_r[j] * clo;
        term5_r[j] <= (TW'(ph4_r[j]) <<< DW) + TW'(pl4_r[j]);
      end
    end
  end

  // Stage 7: magnitudes, signs and the singular decision.
  logic            dneg;
  logic [TW-1:0]   dmag;
  logic            sing;
  logic [NE-1:0]   neg7;
  logic [TW-1:0]   dmag7_r;
  logic [NUM_W-1:0] num7_r [NE];
  mi3_pkg::ctl_t   ctl7_r;

  assign dneg = det6_r[TW-1];
  assign dmag = dneg ? TW'(-det6_r) : TW'(det6_r);
  assign sing = (dmag == '0) ||
                ((dmag[TW-1:mi3_pkg::THR_W] == '0) &&
                 (dmag[mi3_pkg::THR_W-1:0] < thresh_r));

  for (genvar k = 0; k < NE; k++) begin : g_num
    logic [PW-1:0] cmag;
    assign cmag = cof6_r[k][PW-1] ? PW'(-cof6_r[k]) : PW'(cof6_r[k]);
    assign neg7[k] = cof6_r[k][PW-1] ^ dneg;
    always_ff @(posedge clk) begin
      if (en) begin
        num7_r[k] <= NUM_W'(cmag) << (2 * FRAC_BITS);
      end
    end
  end

  // Only the valid bit of the control word is reset.
  always_ff @(posedge clk) begin
    if (en) begin
      dmag7_r         <= dmag;
      ctl7_r.singular <= sing;
      ctl7_r.neg      <= neg7;
    end
    if (!rst_n) begin
      ctl7_r.valid <= 1'b0;
    end else if (en) begin
      ctl7_r.valid <= vld_r[6];
    end
  end

  // Divider lanes, with control delayed to match.
  logic [QW-1:0] quo [NE];
  logic          ovf [NE];
  for (genvar k = 0; k < NE; k++) begin : g_div
    mi3_div #(.NUM_W(NUM_W)) u_div (
      .clk (clk),
      .en  (en),
      .num (num7_r[k]),
      .den (dmag7_r),
      .quo (quo[k]),
      .ovf (ovf[k])
    );
  end

  mi3_pkg::ctl_t ctl_pipe_r [DIV_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_pipe_r[0].singular <= ctl7_r.singular;
      ctl_pipe_r[0].neg      <= ctl7_r.neg;
      for (int i = 1; i < DIV_LAT; i++) begin
        ctl_pipe_r[i].singular <= ctl_pipe_r[i-1].singular;
        ctl_pipe_r[i].neg      <= ctl_pipe_r[i-1].neg;
      end
    end
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) ctl_pipe_r[i].valid <= 1'b0;
    end else if (en) begin
      ctl_pipe_r[0].valid <= ctl7_r.valid;
      for (int i = 1; i < DIV_LAT; i++) begin
        ctl_pipe_r[i].valid <= ctl_pipe_r[i-1].valid;
      end
    end
  end

  // Output stage: sign, saturation and the singular override.
  mi3_pkg::ctl_t        ctl_o;
  logic signed [DW-1:0] res_r [NE];
  logic signed [DW-1:0] res_nxt [NE];
  logic                 sing_r;

  assign ctl_o = ctl_pipe_r[DIV_LAT-1];

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      if (ctl_o.singular) begin
        res_nxt[k] = '0;
      end else if (ctl_o.neg[k]) begin
        res_nxt[k] = (ovf[k] || (quo[k] > NEG_LIM)) ? SAT_MIN : DW'(-quo[k]);
      end else begin
        res_nxt[k] = (ovf[k] || (quo[k] > POS_LIM)) ? SAT_MAX : DW'(quo[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_o.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      sing_r <= ctl_o.singular;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_singular = sing_r;
  assign out_00 = res_r[0]; assign out_01 = res_r[1]; assign out_02 = res_r[2];
  assign out_10 = res_r[3]; assign out_11 = res_r[4]; assign out_12 = res_r[5];
  assign out_20 = res_r[6]; assign out_21 = res_r[7]; assign out_22 = res_r[8];

  // Checks.
  `MI3_ASSERT_NOW(a_sing_zero, out_valid && out_singular,
                  (out_00 == 0) && (out_11 == 0) && (out_22 == 0) &&
                  (out_01 == 0) && (out_12 == 0),
                  "singular result carries nonzero entries")
  `MI3_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall,
                  "input stalled without a held result")
  `MI3_ASSERT_NEXT(a_cfg_write, cfg_wr,
                   thresh_r == $past(cfg_pwdata[mi3_pkg::THR_W-1:0]),
                   "threshold write lost")
  `MI3_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(ctl_o),
                   "pipeline moved while stalled")

endmodule
